>>> rtl/hbl_pkg.sv
// Shared types and constants for the heightmap bilinear lookup block.
// Depends on nothing; every other file of the block imports it.
package hbl_pkg;

   // Default sizing of the grid store and of the interpolation fractions.
   localparam int MAX_POINTS_DEF = 1024;
   localparam int FRAC_BITS_DEF  = 16;

   // Depth of the queue between the front and back parts; a power of two.
   localparam int QUEUE_DEPTH = 4;

   // Widths fixed by the word fields.
   localparam int COORD_W  = 21;
   localparam int PITCH_W  = 20;
   localparam int INV_W    = 32;
   localparam int COUNT_W  = 6;
   localparam int HEIGHT_W = 18;
   localparam int INDEX_W  = 10;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // Operation codes of a request word.
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PITCH_X     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PITCH_Y     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_PITCH_X = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_PITCH_Y = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT_X     = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT_Y     = 3'd7;

   // Result status codes.
   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_OUTSIDE = 3'd1,
      ST_NULL    = 3'd2,
      ST_RANGE   = 3'd3,
      ST_WRITE   = 3'd4
   } status_type;

   // Configuration register set as seen by the front and back parts.
   typedef struct packed {
      logic signed [COORD_W-1:0] origin_x;
      logic signed [COORD_W-1:0] origin_y;
      logic [PITCH_W-1:0]        pitch_x;
      logic [PITCH_W-1:0]        pitch_y;
      logic [INV_W-1:0]          inv_pitch_x;
      logic [INV_W-1:0]          inv_pitch_y;
      logic [COUNT_W-1:0]        count_x;
      logic [COUNT_W-1:0]        count_y;
   } cfg_type;

   // A classified word handed from the front part to the back part.
   typedef struct packed {
      logic                       op;
      logic [INDEX_W-1:0]         point_index;
      logic [HEIGHT_W-1:0]        point_height;
      logic                       point_null;
      status_type                 status;
      logic [COORD_W-1:0]         off_x;
      logic [COORD_W-1:0]         off_y;
   } entry_type;

endpackage

>>> rtl/hbl_if.sv
// Channel interfaces of the heightmap bilinear lookup block.
// Depends on hbl_pkg for the field widths.
interface hbl_req_if;
   import hbl_pkg::*;
   logic                       valid;
   logic                       ready;
   logic                       op;
   logic [INDEX_W-1:0]         point_index;
   logic signed [HEIGHT_W-1:0] point_height;
   logic                       point_null;
   logic signed [COORD_W-1:0]  query_x;
   logic signed [COORD_W-1:0]  query_y;
   logic                       extrapolate;
   modport source (output valid, op, point_index, point_height, point_null, query_x,
                   query_y, extrapolate, input ready);
   modport sink (input valid, op, point_index, point_height, point_null, query_x,
                 query_y, extrapolate, output ready);
endinterface

interface hbl_rsp_if;
   import hbl_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [HEIGHT_W-1:0] height;
   logic [2:0]                 status;
   modport source (output valid, height, status, input ready);
   modport sink (input valid, height, status, output ready);
endinterface

interface hbl_csr_if;
   import hbl_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/heightmap_bilinear_lookup.sv
// Heightmap bilinear lookup: holds a grid of bed heights with null marks and answers
// height queries. It takes one word per clock cycle on the request channel unless the
// result channel stalls it, and gives one result word for each; a word passes through
// the input register, the queue and the back pipeline (stages one to three and the
// output register). The rate is set by the store, kept as two copies with two read
// ports each so all four corners of a cell are read together. Configuration registers
// are always ready; the store holds garbage until written and needs no clearing.
// Depends on hbl_pkg, the channel interfaces and the front, queue and back modules.
module heightmap_bilinear_lookup import hbl_pkg::*; #(
   parameter int MAX_POINTS = MAX_POINTS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   hbl_req_if.sink   req_if,
   hbl_rsp_if.source rsp_if,
   hbl_csr_if.sink   csr_if
);

   cfg_type   cfg_ff;
   logic      push;
   logic      push_ready;
   entry_type push_entry;
   logic      pop;
   logic      pop_valid;
   entry_type pop_entry;

   // Configuration registers.
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin_x <= '0;
         cfg_ff.origin_y <= '0;
         cfg_ff.pitch_x <= PITCH_W'(1);
         cfg_ff.pitch_y <= PITCH_W'(1);
         cfg_ff.inv_pitch_x <= '1;
         cfg_ff.inv_pitch_y <= '1;
         cfg_ff.count_x <= COUNT_W'(2);
         cfg_ff.count_y <= COUNT_W'(2);
      end else if (csr_if.valid) begin
         case (csr_if.index)
            CSR_ORIGIN_X:    cfg_ff.origin_x <= csr_if.data[COORD_W-1:0];
            CSR_ORIGIN_Y:    cfg_ff.origin_y <= csr_if.data[COORD_W-1:0];
            CSR_PITCH_X:     cfg_ff.pitch_x <= csr_if.data[PITCH_W-1:0];
            CSR_PITCH_Y:     cfg_ff.pitch_y <= csr_if.data[PITCH_W-1:0];
            CSR_INV_PITCH_X: cfg_ff.inv_pitch_x <= csr_if.data[INV_W-1:0];
            CSR_INV_PITCH_Y: cfg_ff.inv_pitch_y <= csr_if.data[INV_W-1:0];
            CSR_COUNT_X:     cfg_ff.count_x <= csr_if.data[COUNT_W-1:0];
            CSR_COUNT_Y:     cfg_ff.count_y <= csr_if.data[COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   hbl_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .cfg        (cfg_ff),
      .push       (push),
      .push_entry (push_entry),
      .push_ready (push_ready)
   );

   hbl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry)
   );

   hbl_back #(
      .MAX_POINTS (MAX_POINTS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_entry (pop_entry),
      .pop       (pop),
      .rsp_if    (rsp_if)
   );

endmodule

>>> rtl/hbl_front.sv
// Front part: takes request words, clamps query positions to the grid and classifies them.
// Depends on hbl_pkg and hbl_req_if.
module hbl_front import hbl_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   hbl_req_if.sink    req_if,
   input  cfg_type    cfg,
   output logic       push,
   output entry_type  push_entry,
   input  logic       push_ready
);

   typedef struct packed {
      logic               outside;
      logic               neg;
      logic [COORD_W-1:0] off;
   } axis_type;

   // Clamp one axis to [origin, last point - 10] and return the offset from the origin.
   function automatic axis_type clamp_axis(logic signed [COORD_W-1:0] q,
                                           logic signed [COORD_W-1:0] org,
                                           logic [PITCH_W-1:0] pitch,
                                           logic [COUNT_W-1:0] cnt);
      logic signed [COUNT_W:0] cm1;
      logic signed [27:0]      span;
      logic signed [29:0]      lim;
      logic signed [29:0]      qc;
      logic signed [29:0]      d;
      axis_type                r;
      cm1 = $signed({1'b0, cnt}) - 7'sd1;
      span = 28'(cm1 * $signed({1'b0, pitch}));
      lim = 30'(org) + 30'(span) - 30'sd10;
      r.outside = 1'b0;
      qc = 30'(q);
      if (q < org) begin
         r.outside = 1'b1;
         qc = 30'(org);
      end
      if (qc > lim) begin
         r.outside = 1'b1;
         qc = lim;
      end
      d = qc - 30'(org);
      r.neg = d[29];
      r.off = d[COORD_W-1:0];
      return r;
   endfunction

   logic                       vld_ff;
   logic                       op_ff;
   logic [INDEX_W-1:0]         index_ff;
   logic [HEIGHT_W-1:0]        hgt_ff;
   logic                       null_ff;
   logic signed [COORD_W-1:0]  qx_ff;
   logic signed [COORD_W-1:0]  qy_ff;
   logic                       ext_ff;
   axis_type                   ax;
   axis_type                   ay;
   logic                       take;

   // The input register refills whenever its word moves on to the queue.
   assign req_if.ready = !vld_ff || push_ready;
   assign take = req_if.valid && req_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (req_if.ready) begin
         vld_ff <= req_if.valid;
      end
      if (take) begin
         op_ff    <= req_if.op;
         index_ff <= req_if.point_index;
         hgt_ff   <= req_if.point_height;
         null_ff  <= req_if.point_null;
         qx_ff    <= req_if.query_x;
         qy_ff    <= req_if.query_y;
         ext_ff   <= req_if.extrapolate;
      end
   end

   // Clamp both axes and decide the early status of the word.
   always_comb begin
      ax = clamp_axis(qx_ff, cfg.origin_x, cfg.pitch_x, cfg.count_x);
      ay = clamp_axis(qy_ff, cfg.origin_y, cfg.pitch_y, cfg.count_y);
      push_entry.op = op_ff;
      push_entry.point_index = index_ff;
      push_entry.point_height = hgt_ff;
      push_entry.point_null = null_ff;
      push_entry.off_x = ax.off;
      push_entry.off_y = ay.off;
      if (op_ff == OP_WRITE) begin
         push_entry.status = ST_WRITE;
      end else if ((ax.outside || ay.outside) && !ext_ff) begin
         push_entry.status = ST_OUTSIDE;
      end else if (ax.neg || ay.neg) begin
         push_entry.status = ST_RANGE;
      end else begin
         push_entry.status = ST_OK;
      end
   end

   assign push = vld_ff && push_ready;

endmodule

>>> rtl/hbl_queue.sv
// Short queue of classified words between the front and back parts.
// Depends on hbl_pkg for the entry type and depth.
module hbl_queue import hbl_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      push_ready,
   input  logic      pop,
   output logic      pop_valid,
   output entry_type pop_entry
);

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   entry_type       slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff;
   logic [PW-1:0]   rd_ptr_ff;
   logic [CW-1:0]   count_ff;
   logic            do_pop;

   assign push_ready = count_ff != CW'(QUEUE_DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_entry = slot_ff[rd_ptr_ff];
   assign do_pop = pop && pop_valid;

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (!push && do_pop) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> rtl/hbl_back.sv
// Back part: cell lookup, corner reads from the grid store, bilinear blend and output register.
// Depends on hbl_pkg and hbl_rsp_if.
module hbl_back import hbl_pkg::*; #(
   parameter int MAX_POINTS = MAX_POINTS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      pop_valid,
   input  entry_type pop_entry,
   output logic      pop,
   hbl_rsp_if.source rsp_if
);

   localparam int AW = $clog2(MAX_POINTS);
   localparam int IW = 29;
   localparam int PW = COORD_W + INV_W;
   localparam int BW = HEIGHT_W + FRAC_BITS + 1;
   localparam int RW = BW + FRAC_BITS + 2;
   localparam int EW = HEIGHT_W + 1;

   logic en;

   // Stage one: scale offsets by the reciprocal pitch.
   logic                    s1_vld_ff;
   status_type              s1_status_ff;
   logic                    s1_op_ff;
   logic [INDEX_W-1:0]      s1_index_ff;
   logic [EW-1:0]           s1_wdata_ff;
   logic [COORD_W-1:0]      s1_xi_ff;
   logic [COORD_W-1:0]      s1_yi_ff;
   logic [FRAC_BITS-1:0]    s1_fx_ff;
   logic [FRAC_BITS-1:0]    s1_fy_ff;
   logic [PW-1:0]           px;
   logic [PW-1:0]           py;

   // Stage two: corner indexes, range check and store access.
   logic                    s2_vld_ff;
   status_type              s2_status_ff;
   status_type              s2_status_in;
   logic [FRAC_BITS-1:0]    s2_fx_ff;
   logic [FRAC_BITS-1:0]    s2_fy_ff;
   logic [IW-1:0]           i00;
   logic [IW-1:0]           i_top;
   logic [IW-1:0]           lim_full;
   logic [IW-1:0]           lim;
   logic [AW-1:0]           addr [4];
   logic                    wr_en;
   logic [EW-1:0]           store_a [MAX_POINTS];
   logic [EW-1:0]           store_b [MAX_POINTS];
   logic [EW-1:0]           rd_ff [4];

   // Stage three: blend along X.
   logic                    s3_vld_ff;
   status_type              s3_status_ff;
   status_type              s3_status_in;
   logic [FRAC_BITS-1:0]    s3_fy_ff;
   logic [BW-1:0]           s3_a0_ff;
   logic [BW-1:0]           s3_a1_ff;
   logic [HEIGHT_W-1:0]     z [4];
   logic [FRAC_BITS:0]      wx0;
   logic [FRAC_BITS:0]      wx1;

   // Output register: blend along Y and round.
   logic                    out_vld_ff;
   logic [HEIGHT_W-1:0]     out_height_ff;
   logic [HEIGHT_W-1:0]     out_height_in;
   status_type              out_status_ff;
   logic [FRAC_BITS:0]      wy0;
   logic [FRAC_BITS:0]      wy1;
   logic [RW-1:0]           acc;
   logic [HEIGHT_W-1:0]     r;

   // The whole back pipeline moves together whenever the output register can take a word.
   assign en = !out_vld_ff || rsp_if.ready;
   assign pop = en;

   assign px = PW'(pop_entry.off_x) * PW'(cfg.inv_pitch_x);
   assign py = PW'(pop_entry.off_y) * PW'(cfg.inv_pitch_y);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= pop_valid;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         out_vld_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_status_ff <= pop_entry.status;
         s1_op_ff <= pop_entry.op;
         s1_index_ff <= pop_entry.point_index;
         s1_wdata_ff <= {pop_entry.point_null, pop_entry.point_height};
         s1_xi_ff <= px[PW-1:INV_W];
         s1_yi_ff <= py[PW-1:INV_W];
         s1_fx_ff <= px[INV_W-1 -: FRAC_BITS];
         s1_fy_ff <= py[INV_W-1 -: FRAC_BITS];
      end
   end

   // Corner indexes and the check against the stored points.
   always_comb begin
      i00 = IW'(s1_yi_ff) * IW'(cfg.count_x) + IW'(s1_xi_ff);
      i_top = i00 + IW'(cfg.count_x) + IW'(1);
      lim_full = IW'(cfg.count_x) * IW'(cfg.count_y);
      lim = (lim_full > IW'(MAX_POINTS)) ? IW'(MAX_POINTS) : lim_full;
      addr[0] = i00[AW-1:0];
      addr[1] = AW'(i00 + IW'(1));
      addr[2] = AW'(i00 + IW'(cfg.count_x));
      addr[3] = i_top[AW-1:0];
      if (s1_status_ff == ST_OK && i_top >= lim) begin
         s2_status_in = ST_RANGE;
      end else begin
         s2_status_in = s1_status_ff;
      end
      wr_en = en && s1_vld_ff && s1_op_ff == OP_WRITE &&
              (IW'(s1_index_ff) < IW'(MAX_POINTS));
   end

   // Two copies of the store, each with two read ports, give all four corners at once.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_a[AW'(s1_index_ff)] <= s1_wdata_ff;
         store_b[AW'(s1_index_ff)] <= s1_wdata_ff;
      end
      if (en) begin
         rd_ff[0] <= store_a[addr[0]];
         rd_ff[1] <= store_a[addr[1]];
         rd_ff[2] <= store_b[addr[2]];
         rd_ff[3] <= store_b[addr[3]];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_status_ff <= s2_status_in;
         s2_fx_ff <= s1_fx_ff;
         s2_fy_ff <= s1_fy_ff;
      end
   end

   // Null check, biasing of the corners and the blend along X.
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         z[k] = {~rd_ff[k][HEIGHT_W-1], rd_ff[k][HEIGHT_W-2:0]};
      end
      wx1 = {1'b0, s2_fx_ff};
      wx0 = {1'b1, {FRAC_BITS{1'b0}}} - wx1;
      if (s2_status_ff == ST_OK &&
          (rd_ff[0][HEIGHT_W] || rd_ff[1][HEIGHT_W] ||
           rd_ff[2][HEIGHT_W] || rd_ff[3][HEIGHT_W])) begin
         s3_status_in = ST_NULL;
      end else begin
         s3_status_in = s2_status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_status_ff <= s3_status_in;
         s3_fy_ff <= s2_fy_ff;
         s3_a0_ff <= BW'(z[0]) * BW'(wx0) + BW'(z[1]) * BW'(wx1);
         s3_a1_ff <= BW'(z[2]) * BW'(wx0) + BW'(z[3]) * BW'(wx1);
      end
   end

   // Blend along Y, round half up, remove the bias.
   always_comb begin
      wy1 = {1'b0, s3_fy_ff};
      wy0 = {1'b1, {FRAC_BITS{1'b0}}} - wy1;
      acc = RW'(s3_a0_ff) * RW'(wy0) + RW'(s3_a1_ff) * RW'(wy1) +
            (RW'(1) << (2 * FRAC_BITS - 1));
      r = acc[2 * FRAC_BITS +: HEIGHT_W];
      if (s3_status_ff == ST_OK) begin
         out_height_in = {~r[HEIGHT_W-1], r[HEIGHT_W-2:0]};
      end else begin
         out_height_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_status_ff <= s3_status_ff;
         out_height_ff <= out_height_in;
      end
   end

   assign rsp_if.valid = out_vld_ff;
   assign rsp_if.height = out_height_ff;
   assign rsp_if.status = out_status_ff;

endmodule

>>> test/heightmap_bilinear_lookup_tb.sv
// Self-checking testbench for heightmap_bilinear_lookup: grid writes and bilinear queries.
// Depends on hbl_pkg and the channel interfaces; a scoreboard class predicts every word.
`timescale 1ns / 100ps

module heightmap_bilinear_lookup_tb;
   import hbl_pkg::*;

   localparam int STORE_DEPTH = 1024;
   localparam int FILL_POINTS = 256;
   localparam int FRAC        = 16;
   localparam int EDGE_GAP    = 10;
   localparam int HEIGHT_BIAS = 131072;
   localparam int WATCHDOG    = 5000;
   localparam int TAIL_CYCLES = 20;

   // One request word as the sender builds it.
   typedef struct {
      logic                       op;
      logic [INDEX_W-1:0]         point_index;
      logic signed [HEIGHT_W-1:0] point_height;
      logic                       point_null;
      logic signed [COORD_W-1:0]  query_x;
      logic signed [COORD_W-1:0]  query_y;
      logic                       extrapolate;
   } req_word_type;

   // One expected result word.
   typedef struct {
      logic signed [HEIGHT_W-1:0] height;
      status_type                 status;
   } rsp_word_type;

   // Predicts the lookup results and checks the result words in order.
   class height_scoreboard;
      logic signed [COORD_W-1:0] org_x, org_y;
      logic [PITCH_W-1:0]        pit_x, pit_y;
      logic [INV_W-1:0]          inv_x, inv_y;
      logic [COUNT_W-1:0]        cnt_x, cnt_y;
      logic [HEIGHT_W:0]         grid_copy [STORE_DEPTH];
      rsp_word_type              pending_results [$];
      int                        mismatches;

      function new();
         org_x = 0; org_y = 0; pit_x = 1; pit_y = 1;
         inv_x = '1; inv_y = '1; cnt_x = 2; cnt_y = 2;
         mismatches = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_ORIGIN_X:    org_x = data[COORD_W-1:0];
            CSR_ORIGIN_Y:    org_y = data[COORD_W-1:0];
            CSR_PITCH_X:     pit_x = data[PITCH_W-1:0];
            CSR_PITCH_Y:     pit_y = data[PITCH_W-1:0];
            CSR_INV_PITCH_X: inv_x = data;
            CSR_INV_PITCH_Y: inv_y = data;
            CSR_COUNT_X:     cnt_x = data[COUNT_W-1:0];
            CSR_COUNT_Y:     cnt_y = data[COUNT_W-1:0];
            default: begin
            end
         endcase
      endfunction

      // Clamps one axis to the grid less the edge gap; the upper clamp wins.
      function longint clamp_axis(longint q, longint org, longint pitch, longint cnt,
                                  inout bit outside);
         longint lim;
         lim = org + (cnt - 1) * pitch - EDGE_GAP;
         if (q < org) begin
            outside = 1;
            q = org;
         end
         if (q > lim) begin
            outside = 1;
            q = lim;
         end
         return q - org;
      endfunction

      // Works out the result of an accepted word and updates the grid copy.
      function void note_word(req_word_type w);
         rsp_word_type res;
         bit outside;
         longint dx, dy;
         longint unsigned px, py, xi, yi, fx, fy, i00, lim, a0, a1, r, one;
         longint unsigned z [4];
         longint unsigned idx [4];
         logic [HEIGHT_W:0] e;
         bit is_null;
         res.height = 0;
         outside = 0;
         is_null = 0;
         one = longint'(1) << FRAC;
         if (w.op == OP_WRITE) begin
            grid_copy[w.point_index] = {w.point_null, w.point_height};
            res.status = ST_WRITE;
         end else begin
            dx = clamp_axis(longint'(w.query_x), longint'(org_x), longint'(pit_x),
                            longint'(cnt_x), outside);
            dy = clamp_axis(longint'(w.query_y), longint'(org_y), longint'(pit_y),
                            longint'(cnt_y), outside);
            if (outside && !w.extrapolate) res.status = ST_OUTSIDE;
            else if (dx < 0 || dy < 0) res.status = ST_RANGE;
            else begin
               px = longint'(dx) * longint'(inv_x);
               py = longint'(dy) * longint'(inv_y);
               xi = px >> 32;
               yi = py >> 32;
               fx = (px >> (32 - FRAC)) & (one - 1);
               fy = (py >> (32 - FRAC)) & (one - 1);
               i00 = yi * cnt_x + xi;
               lim = cnt_x * cnt_y;
               if (lim > STORE_DEPTH) lim = STORE_DEPTH;
               if (i00 + cnt_x + 1 >= lim) res.status = ST_RANGE;
               else begin
                  idx[0] = i00;
                  idx[1] = i00 + 1;
                  idx[2] = i00 + cnt_x;
                  idx[3] = i00 + cnt_x + 1;
                  for (int k = 0; k < 4; k++) begin
                     e = grid_copy[idx[k] % STORE_DEPTH];
                     if (e[HEIGHT_W]) is_null = 1;
                     z[k] = longint'(e[HEIGHT_W-1:0]) ^ HEIGHT_BIAS;
                  end
                  if (is_null) res.status = ST_NULL;
                  else begin
                     // Blend along X, then along Y, and round half up.
                     a0 = z[0] * (one - fx) + z[1] * fx;
                     a1 = z[2] * (one - fx) + z[3] * fx;
                     r = (a0 * (one - fy) + a1 * fy + (longint'(1) << (2 * FRAC - 1)))
                         >> (2 * FRAC);
                     res.height = HEIGHT_W'(r - HEIGHT_BIAS);
                     res.status = ST_OK;
                  end
               end
            end
         end
         pending_results = {pending_results, res};
      endfunction

      function void fail_word(string what);
         mismatches++;
         if (mismatches <= 10) $display("%0t: %s", $realtime, what);
      endfunction

      // Compares a result word with the oldest prediction.
      function void check_word(logic signed [HEIGHT_W-1:0] height, logic [2:0] status);
         rsp_word_type exp_word;
         if (pending_results.size() == 0) begin
            fail_word($sformatf("unexpected result word height %0d status %0d",
                                height, status));
            return;
         end
         exp_word = pending_results.pop_front();
         if (height !== exp_word.height || status !== exp_word.status)
            fail_word($sformatf("result mismatch: expected height %0d status %0d, got %0d %0d",
                                exp_word.height, exp_word.status, height, status));
      endfunction

      function int outstanding();
         return pending_results.size();
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;

   hbl_req_if req_bus ();
   hbl_rsp_if rsp_bus ();
   hbl_csr_if csr_bus ();

   heightmap_bilinear_lookup dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   height_scoreboard sb = new();
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_left      = 0;
   int quiet_cycles   = 0;

   always #5 clock = ~clock;

   initial begin
      req_bus.valid = 0; req_bus.op = 0; req_bus.point_index = 0; req_bus.point_height = 0;
      req_bus.point_null = 0; req_bus.query_x = 0; req_bus.query_y = 0;
      req_bus.extrapolate = 0;
      rsp_bus.ready = 0;
      csr_bus.valid = 0; csr_bus.index = 0; csr_bus.data = 0;
   end

   // The receiver stalls at random, or for a long stretch when asked.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_bus.ready <= 0;
         hold_left = hold_left - 1;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Every accepted result word is checked.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) sb.check_word(rsp_bus.height, rsp_bus.status);
   end

   // The watchdog ends a run in which no word moves for too long.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready))
         quiet_cycles = 0;
      else
         quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
         $display("heightmap_bilinear_lookup_tb NOT OK");
         $finish;
      end
   end

   // Offers one word, idling first at random, and notes it when accepted.
   task automatic send_word(req_word_type w);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 0;
         @(negedge clock);
      end
      req_bus.valid        <= 1;
      req_bus.op           <= w.op;
      req_bus.point_index  <= w.point_index;
      req_bus.point_height <= w.point_height;
      req_bus.point_null   <= w.point_null;
      req_bus.query_x      <= w.query_x;
      req_bus.query_y      <= w.query_y;
      req_bus.extrapolate  <= w.extrapolate;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_word(w);
   endtask

   task automatic stop_sending();
      @(negedge clock);
      req_bus.valid <= 0;
   endtask

   // Waits until every predicted result word has arrived.
   task automatic drain();
      stop_sending();
      while (sb.outstanding() > 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_bus.valid <= 1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      do @(posedge clock); while (!csr_bus.ready);
      sb.set_reg(idx, data);
      @(negedge clock);
      csr_bus.valid <= 0;
   endtask

   task automatic set_grid(int ox, int oy, int px, int py, int cx, int cy, bit rand_inv);
      longint unsigned ix, iy;
      ix = ((longint'(1) << 32) + px - 1) / px;
      iy = ((longint'(1) << 32) + py - 1) / py;
      if (ix > 64'hFFFF_FFFF) ix = 64'hFFFF_FFFF;
      if (iy > 64'hFFFF_FFFF) iy = 64'hFFFF_FFFF;
      if (rand_inv) begin
         ix = $urandom_range(32'hFFFF_FFFF, 1);
         iy = $urandom_range(32'hFFFF_FFFF, 1);
      end
      write_reg(CSR_ORIGIN_X, ox);
      write_reg(CSR_ORIGIN_Y, oy);
      write_reg(CSR_PITCH_X, px);
      write_reg(CSR_PITCH_Y, py);
      write_reg(CSR_INV_PITCH_X, ix[31:0]);
      write_reg(CSR_INV_PITCH_Y, iy[31:0]);
      write_reg(CSR_COUNT_X, cx);
      write_reg(CSR_COUNT_Y, cy);
   endtask

   function automatic req_word_type point_word(int index, int height, bit is_null);
      req_word_type w;
      w = '{default: 0};
      w.op = OP_WRITE;
      w.point_index = INDEX_W'(index);
      w.point_height = HEIGHT_W'(height);
      w.point_null = is_null;
      w.query_x = COORD_W'($urandom);
      w.query_y = COORD_W'($urandom);
      w.extrapolate = 1'($urandom);
      return w;
   endfunction

   function automatic req_word_type query_word(int qx, int qy, bit extra);
      req_word_type w;
      w = '{default: 0};
      w.op = OP_QUERY;
      w.query_x = COORD_W'(qx);
      w.query_y = COORD_W'(qy);
      w.extrapolate = extra;
      w.point_index = INDEX_W'($urandom);
      w.point_height = HEIGHT_W'($urandom);
      w.point_null = 1'($urandom);
      return w;
   endfunction

   // Picks a coordinate mostly around the grid along one axis, sometimes anywhere.
   function automatic int pick_coord(int org, int pitch, int cnt);
      longint lo, hi;
      if ($urandom_range(9) < 2) return int'($urandom_range(2000000)) - 1000000;
      lo = longint'(org) - pitch;
      hi = longint'(org) + longint'(cnt) * pitch;
      if (lo < -1000000) lo = -1000000;
      if (hi > 1000000) hi = 1000000;
      if (hi < lo) hi = lo;
      return int'(lo + longint'($urandom_range(32'(hi - lo))));
   endfunction

   task automatic random_words(int n);
      int cells;
      cells = sb.cnt_x * sb.cnt_y;
      if (cells > STORE_DEPTH) cells = STORE_DEPTH;
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(3) == 0)
            send_word(point_word($urandom_range(9) == 0 ? $urandom_range(STORE_DEPTH - 1)
                                                       : $urandom_range(cells - 1),
                                 int'($urandom_range(200000)) - 100000,
                                 $urandom_range(19) == 0));
         else
            send_word(query_word(pick_coord(sb.org_x, sb.pit_x, sb.cnt_x),
                                 pick_coord(sb.org_y, sb.pit_y, sb.cnt_y),
                                 $urandom_range(3) != 0));
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Fill every point that the grids below can reach, so no query reads an unwritten entry.
      for (int k = 0; k < FILL_POINTS; k++)
         send_word(point_word(k, int'($urandom_range(200000)) - 100000, 0));

      // Reset settings: the grid is smaller than the edge gap.
      send_word(query_word(0, 0, 0));
      send_word(query_word(0, 0, 1));
      drain();

      // Directed checks on a 4 by 4 grid with 1 mm pitch.
      set_grid(0, 0, 1000, 1000, 4, 4, 0);
      send_word(point_word(0, 100000, 0));
      send_word(point_word(1, -100000, 0));
      send_word(point_word(4, 0, 0));
      send_word(point_word(5, 1, 0));
      send_word(query_word(0, 0, 0));
      send_word(query_word(500, 500, 0));
      send_word(query_word(999, 1, 1));
      send_word(query_word(-1000000, 500, 0));
      send_word(query_word(-1000000, 500, 1));
      send_word(query_word(1000000, 1000000, 1));
      send_word(query_word(1000000, -1000000, 0));
      send_word(point_word(10, 5, 1));
      send_word(query_word(1500, 2500, 0));
      send_word(query_word(2500, 2500, 1));
      send_word(point_word(10, -7, 0));
      send_word(query_word(1500, 2500, 0));
      send_word(query_word(-1, 0, 1));
      drain();

      // Random phases over several grid settings and idle patterns.
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: set_grid(0, 0, 1000, 1000, 4, 4, 0);
            1: set_grid(-1000000, -1000000, 1, 1, 32, 8, 0);
            2: set_grid(1000000, 1000000, 1000000, 1000000, 2, 2, 0);
            3: set_grid(-50000, 20000, 3000, 7000, 32, 8, 0);
            4: set_grid(-1000000, 1000000, 1000000, 1, 2, 32, 0);
            5: set_grid(1234, -4321, 5000, 2500, 10, 20, 1);
            6: set_grid(-20000, -20000, 1500, 1500, 16, 16, 0);
            default: set_grid(0, 0, 17, 23, 63, 4, 1);
         endcase
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
            default: begin send_idle_pct = 31; recv_stall_pct = 31; end
         endcase
         // Long receiver hold-off while words keep coming.
         if (phase == 4) hold_left = 300;
         random_words(115);
         drain();
      end

      if (sb.outstanding() != 0) sb.fail_word("result words missing at the end");
      if (sb.mismatches == 0)
         $display("heightmap_bilinear_lookup_tb OK");
      else
         $display("heightmap_bilinear_lookup_tb NOT OK");
      $finish;
   end

endmodule
